@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define C8S_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define C8S_NEVER(lbl, ck, rs, expr, msg) \
  `C8S_ASSERT(lbl, ck, rs, !(expr), msg)

`endif

@@ rtl/c8s_pkg.sv @@
// Types and constants for the 8-bit instruction step block.
// No dependencies; imported by c8s_alu, the step module and the testbench.
`default_nettype none

package c8s_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_EXEC = 2'd2;

  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_B = 4;
  localparam int FL_U = 5;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam logic [7:0]  P_RESET     = 8'h24;
  localparam logic [7:0]  P_PUSH_MASK = 8'h30;
  localparam logic [7:0]  STACK_PAGE  = 8'h01;
  localparam logic [15:0] VEC_RESET   = 16'hFFFC;
  localparam logic [15:0] VEC_IRQ     = 16'hFFFE;

  typedef enum logic [3:0] {
    ALU_OR, ALU_AND, ALU_EOR, ALU_ADC, ALU_SBC, ALU_PASS, ALU_CMP, ALU_BIT,
    ALU_ASL, ALU_ROL, ALU_LSR, ALU_ROR, ALU_DEC, ALU_INC
  } alu_op_t;

  typedef enum logic [3:0] {
    K_BAD, K_NOP, K_FLAG, K_REG, K_LOAD, K_CMP, K_STORE, K_RMW, K_BR,
    K_JMP, K_JMPI, K_JSR, K_RTS, K_RTI, K_BRK, K_PUSH
  } kind_t;

  typedef enum logic [3:0] {
    AM_IMP, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABSX, AM_ABSY,
    AM_INDX, AM_INDY, AM_PULL
  } amode_t;

  typedef enum logic [2:0] {
    REG_A, REG_X, REG_Y, REG_SP, REG_P, REG_NONE
  } reg_sel_t;

  typedef struct packed {
    kind_t    kind;
    amode_t   am;
    alu_op_t  alu;
    reg_sel_t rsrc;
    reg_sel_t rdst;
  } dec_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] p;
  } alu_res_t;

endpackage

`default_nettype wire

@@ rtl/c8s_if.sv @@
// Valid/ready channels for commands and results of the instruction step block.
// Depends on nothing.
`default_nettype none

interface c8s_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] mem_addr;
  logic [7:0]  mem_data;
  modport source (output valid, cmd, mem_addr, mem_data, input ready);
  modport sink (input valid, cmd, mem_addr, mem_data, output ready);
endinterface

interface c8s_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] prog_counter;
  logic [7:0]  accum;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [7:0]  stack_ptr;
  logic [7:0]  status_flags;
  logic [7:0]  read_byte;
  logic        bad_opcode;
  modport source (output valid, prog_counter, accum, index_x, index_y, stack_ptr,
                  status_flags, read_byte, bad_opcode, input ready);
  modport sink (input valid, prog_counter, accum, index_x, index_y, stack_ptr,
                status_flags, read_byte, bad_opcode, output ready);
endinterface

`default_nettype wire

@@ rtl/c8s_ram.sv @@
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module c8s_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/c8s_alu.sv @@
// Shared 8-bit arithmetic, logic, compare and shift unit with flag update.
// Depends on c8s_pkg.
`default_nettype none

module c8s_alu import c8s_pkg::*; (
  input  wire alu_op_t    op,
  input  wire logic [7:0] a,
  input  wire logic [7:0] m,
  input  wire logic [7:0] p_in,
  output alu_res_t        res
);

  logic [7:0] mo;
  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] r;
  logic [7:0] p;

  always_comb begin
    mo   = (op == ALU_SBC) ? ~m : m;
    sum  = {1'b0, a} + {1'b0, mo} + {8'd0, p_in[FL_C]};
    diff = {1'b0, a} - {1'b0, m};
    r    = a;
    p    = p_in;
    unique case (op)
      ALU_OR:  r = a | m;
      ALU_AND: r = a & m;
      ALU_EOR: r = a ^ m;
      ALU_ADC, ALU_SBC: begin
        r       = sum[7:0];
        p[FL_C] = sum[8];
        p[FL_V] = ~(a[7] ^ mo[7]) & (a[7] ^ sum[7]);
      end
      ALU_PASS: r = m;
      ALU_CMP: begin
        r       = diff[7:0];
        p[FL_C] = ~diff[8];
      end
      ALU_BIT: begin
        r       = a & m;
        p[FL_V] = m[6];
      end
      ALU_ASL: begin
        p[FL_C] = m[7];
        r       = {m[6:0], 1'b0};
      end
      ALU_ROL: begin
        p[FL_C] = m[7];
        r       = {m[6:0], p_in[FL_C]};
      end
      ALU_LSR: begin
        p[FL_C] = m[0];
        r       = {1'b0, m[7:1]};
      end
      ALU_ROR: begin
        p[FL_C] = m[0];
        r       = {p_in[FL_C], m[7:1]};
      end
      ALU_DEC: r = m - 8'd1;
      ALU_INC: r = m + 8'd1;
      default: r = a;
    endcase
    p[FL_Z] = (r == 8'd0);
    p[FL_N] = (op == ALU_BIT) ? m[7] : r[7];
    res.r = r;
    res.p = p;
  end

endmodule

`default_nettype wire

@@ rtl/cpu_8bit_instruction_step.sv @@
// Command-driven 8-bit processor step: memory load/read and single instructions.
// Depends on c8s_pkg, c8s_if, c8s_ram and c8s_alu.
//
// Usage: cmd_ch takes one command per beat (load byte, read byte, execute one
// instruction); res_ch returns one result beat per command with PC, A, X, Y,
// SP, flags, the byte read and an unknown-opcode flag.
// Every memory access goes through one single-ported RAM: an address state
// (S_RD or S_WR), then the return state, which takes any read data from the
// RAM's output register. The first execute after reset only fetches the reset
// vector into PC. One command is in flight at a time: cmd_ch.ready is high
// only while the block is idle.
// The result holds on res_ch while the receiver stalls; no new command is
// taken until that beat is delivered.
// Reset clears PC, A, X, Y, SP, sets flags to 0x24 and clears the init mark;
// memory contents are not cleared, so only written bytes may be read.
`default_nettype none

module cpu_8bit_instruction_step import c8s_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  c8s_cmd_if.sink   cmd_ch,
  c8s_res_if.source res_ch
);

  typedef enum logic [22:0] {
    S_IDLE   = 23'h000001,
    S_RD     = 23'h000002,
    S_WR     = 23'h000004,
    S_OUT    = 23'h000008,
    S_RB     = 23'h000010,
    S_V1     = 23'h000020,
    S_V2     = 23'h000040,
    S_DEC    = 23'h000080,
    S_DISP   = 23'h000100,
    S_B1     = 23'h000200,
    S_B2     = 23'h000400,
    S_P1     = 23'h000800,
    S_P2     = 23'h001000,
    S_EA     = 23'h002000,
    S_EXE    = 23'h004000,
    S_PULLD  = 23'h008000,
    S_PULLLO = 23'h010000,
    S_PULLHI = 23'h020000,
    S_PUSHHI = 23'h040000,
    S_PUSHLO = 23'h080000,
    S_PUSHP  = 23'h100000,
    S_VEC    = 23'h200000,
    S_JDONE  = 23'h400000
  } state_t;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t       d;
    logic [2:0] sel;
    logic [2:0] bbb;
    d   = '{kind: K_BAD, am: AM_IMP, alu: ALU_PASS, rsrc: REG_A, rdst: REG_NONE};
    sel = op[7:5];
    bbb = op[4:2];
    unique case (op)
      8'h00: d.kind = K_BRK;
      8'h08: begin d.kind = K_PUSH; d.rsrc = REG_P; end
      8'h48: begin d.kind = K_PUSH; d.rsrc = REG_A; end
      8'h28: begin d.kind = K_PUSH; d.am = AM_PULL; d.rdst = REG_P; end
      8'h68: begin d.kind = K_PUSH; d.am = AM_PULL; d.rdst = REG_A; end
      8'h40: d.kind = K_RTI;
      8'h60: d.kind = K_RTS;
      8'h20: begin d.kind = K_JSR; d.am = AM_ABS; end
      8'h4C: begin d.kind = K_JMP; d.am = AM_ABS; end
      8'h6C: begin d.kind = K_JMPI; d.am = AM_ABS; end
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: begin
        d.kind = K_BR; d.am = AM_ZP;
      end
      8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8: d.kind = K_FLAG;
      8'h24: begin d.kind = K_CMP; d.am = AM_ZP;  d.alu = ALU_BIT; end
      8'h2C: begin d.kind = K_CMP; d.am = AM_ABS; d.alu = ALU_BIT; end
      8'h84: begin d.kind = K_STORE; d.am = AM_ZP;  d.rsrc = REG_Y; end
      8'h8C: begin d.kind = K_STORE; d.am = AM_ABS; d.rsrc = REG_Y; end
      8'h94: begin d.kind = K_STORE; d.am = AM_ZPX; d.rsrc = REG_Y; end
      8'h86: begin d.kind = K_STORE; d.am = AM_ZP;  d.rsrc = REG_X; end
      8'h8E: begin d.kind = K_STORE; d.am = AM_ABS; d.rsrc = REG_X; end
      8'h96: begin d.kind = K_STORE; d.am = AM_ZPY; d.rsrc = REG_X; end
      8'hA0: begin d.kind = K_LOAD; d.am = AM_IMM;  d.rdst = REG_Y; end
      8'hA4: begin d.kind = K_LOAD; d.am = AM_ZP;   d.rdst = REG_Y; end
      8'hAC: begin d.kind = K_LOAD; d.am = AM_ABS;  d.rdst = REG_Y; end
      8'hB4: begin d.kind = K_LOAD; d.am = AM_ZPX;  d.rdst = REG_Y; end
      8'hBC: begin d.kind = K_LOAD; d.am = AM_ABSX; d.rdst = REG_Y; end
      8'hA2: begin d.kind = K_LOAD; d.am = AM_IMM;  d.rdst = REG_X; end
      8'hA6: begin d.kind = K_LOAD; d.am = AM_ZP;   d.rdst = REG_X; end
      8'hAE: begin d.kind = K_LOAD; d.am = AM_ABS;  d.rdst = REG_X; end
      8'hB6: begin d.kind = K_LOAD; d.am = AM_ZPY;  d.rdst = REG_X; end
      8'hBE: begin d.kind = K_LOAD; d.am = AM_ABSY; d.rdst = REG_X; end
      8'hC0: begin d.kind = K_CMP; d.am = AM_IMM; d.alu = ALU_CMP; d.rsrc = REG_Y; end
      8'hC4: begin d.kind = K_CMP; d.am = AM_ZP;  d.alu = ALU_CMP; d.rsrc = REG_Y; end
      8'hCC: begin d.kind = K_CMP; d.am = AM_ABS; d.alu = ALU_CMP; d.rsrc = REG_Y; end
      8'hE0: begin d.kind = K_CMP; d.am = AM_IMM; d.alu = ALU_CMP; d.rsrc = REG_X; end
      8'hE4: begin d.kind = K_CMP; d.am = AM_ZP;  d.alu = ALU_CMP; d.rsrc = REG_X; end
      8'hEC: begin d.kind = K_CMP; d.am = AM_ABS; d.alu = ALU_CMP; d.rsrc = REG_X; end
      8'h88: begin d.kind = K_REG; d.alu = ALU_DEC; d.rsrc = REG_Y; d.rdst = REG_Y; end
      8'hC8: begin d.kind = K_REG; d.alu = ALU_INC; d.rsrc = REG_Y; d.rdst = REG_Y; end
      8'hCA: begin d.kind = K_REG; d.alu = ALU_DEC; d.rsrc = REG_X; d.rdst = REG_X; end
      8'hE8: begin d.kind = K_REG; d.alu = ALU_INC; d.rsrc = REG_X; d.rdst = REG_X; end
      8'h8A: begin d.kind = K_REG; d.rsrc = REG_X;  d.rdst = REG_A; end
      8'h98: begin d.kind = K_REG; d.rsrc = REG_Y;  d.rdst = REG_A; end
      8'h9A: begin d.kind = K_REG; d.rsrc = REG_X;  d.rdst = REG_SP; end
      8'hA8: begin d.kind = K_REG; d.rsrc = REG_A;  d.rdst = REG_Y; end
      8'hAA: begin d.kind = K_REG; d.rsrc = REG_A;  d.rdst = REG_X; end
      8'hBA: begin d.kind = K_REG; d.rsrc = REG_SP; d.rdst = REG_X; end
      8'hEA: d.kind = K_NOP;
      8'h0A: begin d.kind = K_REG; d.alu = ALU_ASL; d.rdst = REG_A; end
      8'h2A: begin d.kind = K_REG; d.alu = ALU_ROL; d.rdst = REG_A; end
      8'h4A: begin d.kind = K_REG; d.alu = ALU_LSR; d.rdst = REG_A; end
      8'h6A: begin d.kind = K_REG; d.alu = ALU_ROR; d.rdst = REG_A; end
      default: begin
        if (op[1:0] == 2'b01 && !(sel == 3'd4 && bbb == 3'd2)) begin
          unique case (bbb)
            3'd0: d.am = AM_INDX;
            3'd1: d.am = AM_ZP;
            3'd2: d.am = AM_IMM;
            3'd3: d.am = AM_ABS;
            3'd4: d.am = AM_INDY;
            3'd5: d.am = AM_ZPX;
            3'd6: d.am = AM_ABSY;
            default: d.am = AM_ABSX;
          endcase
          d.kind = K_LOAD;
          d.rdst = REG_A;
          unique case (sel)
            3'd0: d.alu = ALU_OR;
            3'd1: d.alu = ALU_AND;
            3'd2: d.alu = ALU_EOR;
            3'd3: d.alu = ALU_ADC;
            3'd4: begin d.kind = K_STORE; d.rdst = REG_NONE; end
            3'd5: d.alu = ALU_PASS;
            3'd6: begin d.kind = K_CMP; d.alu = ALU_CMP; d.rdst = REG_NONE; end
            default: d.alu = ALU_SBC;
          endcase
        end else if (op[1:0] == 2'b10 && bbb[0] && sel != 3'd4 && sel != 3'd5) begin
          d.kind = K_RMW;
          unique case (bbb)
            3'd1: d.am = AM_ZP;
            3'd3: d.am = AM_ABS;
            3'd5: d.am = AM_ZPX;
            default: d.am = AM_ABSX;
          endcase
          unique case (sel)
            3'd0: d.alu = ALU_ASL;
            3'd1: d.alu = ALU_ROL;
            3'd2: d.alu = ALU_LSR;
            3'd3: d.alu = ALU_ROR;
            3'd6: d.alu = ALU_DEC;
            default: d.alu = ALU_INC;
          endcase
        end
      end
    endcase
    return d;
  endfunction

  state_t     state;
  state_t     ret_state;
  logic       started;
  logic [15:0] pc;
  logic [7:0] acc;
  logic [7:0] xr;
  logic [7:0] yr;
  logic [7:0] sp;
  logic [7:0] p;
  logic [7:0] rb;
  logic       bad;
  logic [15:0] ma;
  logic [7:0] wdat;
  logic [7:0] lo;
  logic [15:0] ptr;
  logic [7:0] opq;
  dec_t       dq;

  logic [7:0] rdata;
  logic       ram_en;
  logic       ram_we;
  logic [7:0] src_val;
  logic [7:0] alu_m;
  alu_res_t   alu_res;
  logic       br_flag;
  logic       br_take;
  logic [2:0] fl_idx;
  logic       fl_val;
  logic       dst_we;
  logic       flag_we;
  logic [7:0] plp_val;

  c8s_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ma[ADDR_BITS-1:0]),
    .wdata (wdat),
    .rdata (rdata)
  );

  c8s_alu u_alu (
    .op   (dq.alu),
    .a    (src_val),
    .m    (alu_m),
    .p_in (p),
    .res  (alu_res)
  );

  always_comb begin
    ram_en = (state == S_RD) || (state == S_WR);
    ram_we = (state == S_WR);
    unique case (dq.rsrc)
      REG_A:   src_val = acc;
      REG_X:   src_val = xr;
      REG_Y:   src_val = yr;
      REG_SP:  src_val = sp;
      REG_P:   src_val = p | P_PUSH_MASK;
      default: src_val = 8'd0;
    endcase
    alu_m = (state == S_DISP) ? src_val : rdata;
    unique case (opq[7:6])
      2'd0:    br_flag = p[FL_N];
      2'd1:    br_flag = p[FL_V];
      2'd2:    br_flag = p[FL_C];
      default: br_flag = p[FL_Z];
    endcase
    br_take = (br_flag == opq[5]);
    unique case (opq[7:6])
      2'd0:    fl_idx = 3'(FL_C);
      2'd1:    fl_idx = 3'(FL_I);
      2'd2:    fl_idx = 3'(FL_V);
      default: fl_idx = 3'(FL_D);
    endcase
    // CLV shares the set pattern but always clears
    fl_val  = opq[5] && (opq[7:6] != 2'd2);
    plp_val = (rdata | (8'd1 << FL_U)) & ~(8'd1 << FL_B);
    dst_we  = (state == S_DISP && dq.kind == K_REG)
           || (state == S_EXE && dq.kind == K_LOAD)
           || (state == S_PULLD && dq.kind == K_PUSH && dq.rdst == REG_A);
    flag_we = (dst_we && dq.rdst != REG_SP)
           || (state == S_EXE && (dq.kind == K_CMP || dq.kind == K_RMW));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      started   <= 1'b0;
      pc        <= 16'd0;
      acc       <= 8'd0;
      xr        <= 8'd0;
      yr        <= 8'd0;
      sp        <= 8'd0;
      p         <= P_RESET;
      rb        <= 8'd0;
      bad       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_ch.valid) begin
            rb  <= 8'd0;
            bad <= 1'b0;
            priority if (cmd_ch.cmd == CMD_LOAD) begin
              ma        <= cmd_ch.mem_addr;
              wdat      <= cmd_ch.mem_data;
              state     <= S_WR;
              ret_state <= S_OUT;
            end else if (cmd_ch.cmd == CMD_READ) begin
              ma        <= cmd_ch.mem_addr;
              state     <= S_RD;
              ret_state <= S_RB;
            end else if (cmd_ch.cmd == CMD_EXEC) begin
              state <= S_RD;
              if (!started) begin
                started   <= 1'b1;
                ma        <= VEC_RESET;
                ret_state <= S_V1;
              end else begin
                ma        <= pc;
                pc        <= pc + 16'd1;
                ret_state <= S_DEC;
              end
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_RD, S_WR: state <= ret_state;
        S_RB: begin
          rb    <= rdata;
          state <= S_OUT;
        end
        S_V1: begin
          lo        <= rdata;
          ma        <= ma + 16'd1;
          state     <= S_RD;
          ret_state <= S_V2;
        end
        S_V2: begin
          pc    <= {rdata, lo};
          state <= S_OUT;
        end
        S_DEC: begin
          opq   <= rdata;
          dq    <= decode(rdata);
          state <= S_DISP;
        end
        S_DISP: begin
          unique case (dq.kind)
            K_BAD: begin
              bad   <= 1'b1;
              state <= S_OUT;
            end
            K_NOP, K_REG: state <= S_OUT;
            K_FLAG: begin
              p[fl_idx] <= fl_val;
              state     <= S_OUT;
            end
            K_PUSH: begin
              if (dq.am == AM_PULL) begin
                sp        <= sp + 8'd1;
                ma        <= {STACK_PAGE, sp + 8'd1};
                state     <= S_RD;
                ret_state <= S_PULLD;
              end else begin
                ma        <= {STACK_PAGE, sp};
                wdat      <= src_val;
                sp        <= sp - 8'd1;
                state     <= S_WR;
                ret_state <= S_OUT;
              end
            end
            K_RTI, K_RTS: begin
              sp        <= sp + 8'd1;
              ma        <= {STACK_PAGE, sp + 8'd1};
              state     <= S_RD;
              ret_state <= S_PULLD;
            end
            K_BRK: begin
              // skip the padding byte
              pc    <= pc + 16'd1;
              state <= S_PUSHHI;
            end
            default: begin
              ma <= pc;
              pc <= pc + 16'd1;
              if (dq.am == AM_IMM) begin
                state <= S_EA;
              end else begin
                state     <= S_RD;
                ret_state <= S_B1;
              end
            end
          endcase
        end
        S_B1: begin
          lo <= rdata;
          if (dq.kind == K_BR) begin
            if (br_take) begin
              pc <= pc + {{8{rdata[7]}}, rdata};
            end
            state <= S_OUT;
          end else begin
            unique case (dq.am)
              AM_ZP: begin
                ma    <= {8'd0, rdata};
                state <= S_EA;
              end
              AM_ZPX: begin
                ma    <= {8'd0, rdata + xr};
                state <= S_EA;
              end
              AM_ZPY: begin
                ma    <= {8'd0, rdata + yr};
                state <= S_EA;
              end
              AM_INDX: begin
                ma        <= {8'd0, rdata + xr};
                state     <= S_RD;
                ret_state <= S_P1;
              end
              AM_INDY: begin
                ma        <= {8'd0, rdata};
                state     <= S_RD;
                ret_state <= S_P1;
              end
              default: begin
                ma        <= pc;
                pc        <= pc + 16'd1;
                state     <= S_RD;
                ret_state <= S_B2;
              end
            endcase
          end
        end
        S_B2: begin
          unique case (dq.kind)
            K_JMP: begin
              pc    <= {rdata, lo};
              state <= S_OUT;
            end
            K_JSR: begin
              ptr   <= {rdata, lo};
              pc    <= pc - 16'd1;
              state <= S_PUSHHI;
            end
            K_JMPI: begin
              ma        <= {rdata, lo};
              state     <= S_RD;
              ret_state <= S_P1;
            end
            default: begin
              if (dq.am == AM_ABSX) begin
                ma <= {rdata, lo} + {8'd0, xr};
              end else if (dq.am == AM_ABSY) begin
                ma <= {rdata, lo} + {8'd0, yr};
              end else begin
                ma <= {rdata, lo};
              end
              state <= S_EA;
            end
          endcase
        end
        S_P1: begin
          // high byte stays within the pointer's page
          lo        <= rdata;
          ma        <= {ma[15:8], ma[7:0] + 8'd1};
          state     <= S_RD;
          ret_state <= S_P2;
        end
        S_P2: begin
          if (dq.kind == K_JMPI) begin
            pc    <= {rdata, lo};
            state <= S_OUT;
          end else if (dq.am == AM_INDY) begin
            ma    <= {rdata, lo} + {8'd0, yr};
            state <= S_EA;
          end else begin
            ma    <= {rdata, lo};
            state <= S_EA;
          end
        end
        S_EA: begin
          if (dq.kind == K_STORE) begin
            wdat      <= src_val;
            state     <= S_WR;
            ret_state <= S_OUT;
          end else begin
            state     <= S_RD;
            ret_state <= S_EXE;
          end
        end
        S_EXE: begin
          if (dq.kind == K_RMW) begin
            wdat      <= alu_res.r;
            state     <= S_WR;
            ret_state <= S_OUT;
          end else begin
            state <= S_OUT;
          end
        end
        S_PULLD: begin
          unique case (dq.kind)
            K_RTI: begin
              p         <= plp_val;
              sp        <= sp + 8'd1;
              ma        <= {STACK_PAGE, sp + 8'd1};
              state     <= S_RD;
              ret_state <= S_PULLLO;
            end
            K_RTS: begin
              lo        <= rdata;
              sp        <= sp + 8'd1;
              ma        <= {STACK_PAGE, sp + 8'd1};
              state     <= S_RD;
              ret_state <= S_PULLHI;
            end
            default: begin
              if (dq.rdst == REG_P) begin
                p <= plp_val;
              end
              state <= S_OUT;
            end
          endcase
        end
        S_PULLLO: begin
          lo        <= rdata;
          sp        <= sp + 8'd1;
          ma        <= {STACK_PAGE, sp + 8'd1};
          state     <= S_RD;
          ret_state <= S_PULLHI;
        end
        S_PULLHI: begin
          pc    <= {rdata, lo} + ((dq.kind == K_RTS) ? 16'd1 : 16'd0);
          state <= S_OUT;
        end
        S_PUSHHI: begin
          ma        <= {STACK_PAGE, sp};
          wdat      <= pc[15:8];
          sp        <= sp - 8'd1;
          state     <= S_WR;
          ret_state <= S_PUSHLO;
        end
        S_PUSHLO: begin
          ma        <= {STACK_PAGE, sp};
          wdat      <= pc[7:0];
          sp        <= sp - 8'd1;
          state     <= S_WR;
          ret_state <= (dq.kind == K_BRK) ? S_PUSHP : S_JDONE;
        end
        S_PUSHP: begin
          ma        <= {STACK_PAGE, sp};
          wdat      <= p | P_PUSH_MASK;
          sp        <= sp - 8'd1;
          p[FL_I]   <= 1'b1;
          state     <= S_WR;
          ret_state <= S_VEC;
        end
        S_VEC: begin
          ma        <= VEC_IRQ;
          state     <= S_RD;
          ret_state <= S_V1;
        end
        S_JDONE: begin
          pc    <= ptr;
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (dst_we) begin
        unique case (dq.rdst)
          REG_A:   acc <= alu_res.r;
          REG_X:   xr  <= alu_res.r;
          REG_Y:   yr  <= alu_res.r;
          REG_SP:  sp  <= alu_res.r;
          default: acc <= acc;
        endcase
      end
      if (flag_we) begin
        p <= alu_res.p;
      end
    end
  end

  assign cmd_ch.ready        = (state == S_IDLE);
  assign res_ch.valid        = (state == S_OUT);
  assign res_ch.prog_counter = pc;
  assign res_ch.accum        = acc;
  assign res_ch.index_x      = xr;
  assign res_ch.index_y      = yr;
  assign res_ch.stack_ptr    = sp;
  assign res_ch.status_flags = p;
  assign res_ch.read_byte    = rb;
  assign res_ch.bad_opcode   = bad;

endmodule

`default_nettype wire

@@ rtl/c8s_checker.sv @@
// Port-level checks on the command and result handshakes of the step block.
// Depends on assert_macros.svh; bound to cpu_8bit_instruction_step below.
`default_nettype none
`include "assert_macros.svh"

module c8s_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  `C8S_NEVER(a_busy_excl, clk, rst, in_ready && out_valid, "ready while result pending")
  `C8S_ASSERT(a_one_cmd, clk, rst, in_valid && in_ready |=> !in_ready, "second beat taken")
  `C8S_ASSERT(a_res_once, clk, rst, out_valid && out_ready |=> !out_valid, "result repeated")
  `C8S_ASSERT(a_res_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")

endmodule

bind cpu_8bit_instruction_step c8s_checker u_c8s_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd_ch.valid),
  .in_ready  (cmd_ch.ready),
  .out_valid (res_ch.valid),
  .out_ready (res_ch.ready)
);

`default_nettype wire

@@ sim/tb_cpu_8bit_instruction_step.sv @@
// Testbench for cpu_8bit_instruction_step: a self-checking run over the command channel.
// Depends on c8s_pkg, c8s_if and the block itself.
`timescale 1ns / 1ps

module tb_cpu_8bit_instruction_step;
  import c8s_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 1950;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [7:0]  rb;
    logic        bad;
  } cpu_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  c8s_cmd_if cmd_ch();
  c8s_res_if res_ch();

  cpu_8bit_instruction_step u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow machine state
  logic [7:0]  mem_img [0:65535];
  bit          mem_set [0:65535];
  int unsigned written_addrs[$];
  logic [15:0] c_pc;
  logic [7:0]  c_a, c_x, c_y, c_sp, c_p;
  bit          c_started;
  bit          dry;
  int unsigned missing[$];

  cpu_view_t expected_views[$];
  int mismatches = 0;
  int n_sent = 0;
  int n_exec = 0;
  int n_bad = 0;
  bit no_idle = 0;
  bit hold_req = 0;
  int rx_wait = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [7:0] mrd(input int unsigned addr);
    addr = addr & 32'hFFFF;
    if (!mem_set[addr] && dry) missing.push_back(addr);
    return mem_img[addr];
  endfunction

  function automatic void mwr(input int unsigned addr, input logic [7:0] v);
    addr = addr & 32'hFFFF;
    if (!dry) begin
      if (!mem_set[addr]) written_addrs.push_back(addr);
      mem_set[addr] = 1'b1;
      mem_img[addr] = v;
    end
  endfunction

  function automatic logic [7:0] fetch8();
    logic [7:0] v;
    v = mrd(c_pc);
    c_pc = c_pc + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] fetch16();
    logic [7:0] lo, hi;
    lo = fetch8();
    hi = fetch8();
    return {hi, lo};
  endfunction

  function automatic void push8(input logic [7:0] v);
    mwr({STACK_PAGE, c_sp}, v);
    c_sp = c_sp - 8'd1;
  endfunction

  function automatic logic [7:0] pull8();
    c_sp = c_sp + 8'd1;
    return mrd({STACK_PAGE, c_sp});
  endfunction

  function automatic void set_nz(input logic [7:0] v);
    c_p[FL_Z] = (v == 8'd0);
    c_p[FL_N] = v[7];
  endfunction

  function automatic void cmp8(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] d;
    d = r - m;
    c_p[FL_C] = (r >= m);
    set_nz(d);
  endfunction

  function automatic void add8(input logic [7:0] m);
    logic [8:0] s;
    logic [7:0] vx;
    s = {1'b0, c_a} + {1'b0, m} + {8'd0, c_p[FL_C]};
    vx = ~(c_a ^ m) & (c_a ^ s[7:0]);
    c_p[FL_C] = s[8];
    c_p[FL_V] = vx[7];
    c_a = s[7:0];
    set_nz(c_a);
  endfunction

  function automatic logic [15:0] ea_imm();
    logic [15:0] a;
    a = c_pc;
    c_pc = c_pc + 16'd1;
    return a;
  endfunction

  function automatic logic [15:0] ea_zp_idx(input logic [7:0] idx);
    logic [7:0] z;
    z = fetch8() + idx;
    return {8'h00, z};
  endfunction

  function automatic logic [15:0] ea_zpptr(input logic [7:0] z);
    logic [7:0] z1;
    z1 = z + 8'd1;
    return {mrd({8'h00, z1}), mrd({8'h00, z})};
  endfunction

  function automatic logic [7:0] shift_step(input logic [2:0] sel, input logic [7:0] v);
    logic c;
    logic [7:0] r;
    c = c_p[FL_C];
    case (sel)
      3'd0: begin c_p[FL_C] = v[7]; r = {v[6:0], 1'b0}; end
      3'd1: begin c_p[FL_C] = v[7]; r = {v[6:0], c}; end
      3'd2: begin c_p[FL_C] = v[0]; r = {1'b0, v[7:1]}; end
      3'd3: begin c_p[FL_C] = v[0]; r = {c, v[7:1]}; end
      3'd6: r = v - 8'd1;
      default: r = v + 8'd1;
    endcase
    set_nz(r);
    return r;
  endfunction

  // Returns 1 for an official opcode
  function automatic bit cpu_execute();
    logic [7:0]  op, m, off, lo, hi;
    logic [2:0]  sel, bbb;
    logic [15:0] a, r;
    logic        fl;
    op = fetch8();
    sel = op[7:5];
    bbb = op[4:2];
    case (op)
      8'h00: begin
        c_pc = c_pc + 16'd1;
        push8(c_pc[15:8]);
        push8(c_pc[7:0]);
        push8(c_p | P_PUSH_MASK);
        c_p[FL_I] = 1'b1;
        c_pc = {mrd(VEC_IRQ + 16'd1), mrd(VEC_IRQ)};
        return 1'b1;
      end
      8'h08: begin push8(c_p | P_PUSH_MASK); return 1'b1; end
      8'h28: begin c_p = (pull8() | 8'h20) & 8'hEF; return 1'b1; end
      8'h48: begin push8(c_a); return 1'b1; end
      8'h68: begin c_a = pull8(); set_nz(c_a); return 1'b1; end
      8'h40: begin
        c_p = (pull8() | 8'h20) & 8'hEF;
        lo = pull8();
        hi = pull8();
        c_pc = {hi, lo};
        return 1'b1;
      end
      8'h60: begin
        lo = pull8();
        hi = pull8();
        c_pc = {hi, lo} + 16'd1;
        return 1'b1;
      end
      8'h20: begin
        a = fetch16();
        r = c_pc - 16'd1;
        push8(r[15:8]);
        push8(r[7:0]);
        c_pc = a;
        return 1'b1;
      end
      8'h4C: begin c_pc = fetch16(); return 1'b1; end
      8'h6C: begin
        // high byte stays in the pointer's page
        a = fetch16();
        lo = mrd(a);
        m = a[7:0] + 8'd1;
        hi = mrd({a[15:8], m});
        c_pc = {hi, lo};
        return 1'b1;
      end
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: begin
        off = fetch8();
        case (op[7:6])
          2'd0: fl = c_p[FL_N];
          2'd1: fl = c_p[FL_V];
          2'd2: fl = c_p[FL_C];
          default: fl = c_p[FL_Z];
        endcase
        if (fl == op[5]) c_pc = c_pc + {{8{off[7]}}, off};
        return 1'b1;
      end
      8'h18: begin c_p[FL_C] = 1'b0; return 1'b1; end
      8'h38: begin c_p[FL_C] = 1'b1; return 1'b1; end
      8'h58: begin c_p[FL_I] = 1'b0; return 1'b1; end
      8'h78: begin c_p[FL_I] = 1'b1; return 1'b1; end
      8'hB8: begin c_p[FL_V] = 1'b0; return 1'b1; end
      8'hD8: begin c_p[FL_D] = 1'b0; return 1'b1; end
      8'hF8: begin c_p[FL_D] = 1'b1; return 1'b1; end
      8'h24, 8'h2C: begin
        m = mrd(op == 8'h24 ? ea_zp_idx(8'd0) : fetch16());
        c_p[FL_Z] = ((c_a & m) == 8'd0);
        c_p[FL_N] = m[7];
        c_p[FL_V] = m[6];
        return 1'b1;
      end
      8'h84: begin mwr(ea_zp_idx(8'd0), c_y); return 1'b1; end
      8'h8C: begin mwr(fetch16(), c_y); return 1'b1; end
      8'h94: begin mwr(ea_zp_idx(c_x), c_y); return 1'b1; end
      8'h86: begin mwr(ea_zp_idx(8'd0), c_x); return 1'b1; end
      8'h8E: begin mwr(fetch16(), c_x); return 1'b1; end
      8'h96: begin mwr(ea_zp_idx(c_y), c_x); return 1'b1; end
      8'hA0: begin c_y = mrd(ea_imm()); set_nz(c_y); return 1'b1; end
      8'hA4: begin c_y = mrd(ea_zp_idx(8'd0)); set_nz(c_y); return 1'b1; end
      8'hAC: begin c_y = mrd(fetch16()); set_nz(c_y); return 1'b1; end
      8'hB4: begin c_y = mrd(ea_zp_idx(c_x)); set_nz(c_y); return 1'b1; end
      8'hBC: begin c_y = mrd(fetch16() + {8'd0, c_x}); set_nz(c_y); return 1'b1; end
      8'hA2: begin c_x = mrd(ea_imm()); set_nz(c_x); return 1'b1; end
      8'hA6: begin c_x = mrd(ea_zp_idx(8'd0)); set_nz(c_x); return 1'b1; end
      8'hAE: begin c_x = mrd(fetch16()); set_nz(c_x); return 1'b1; end
      8'hB6: begin c_x = mrd(ea_zp_idx(c_y)); set_nz(c_x); return 1'b1; end
      8'hBE: begin c_x = mrd(fetch16() + {8'd0, c_y}); set_nz(c_x); return 1'b1; end
      8'hC0: begin cmp8(c_y, mrd(ea_imm())); return 1'b1; end
      8'hC4: begin cmp8(c_y, mrd(ea_zp_idx(8'd0))); return 1'b1; end
      8'hCC: begin cmp8(c_y, mrd(fetch16())); return 1'b1; end
      8'hE0: begin cmp8(c_x, mrd(ea_imm())); return 1'b1; end
      8'hE4: begin cmp8(c_x, mrd(ea_zp_idx(8'd0))); return 1'b1; end
      8'hEC: begin cmp8(c_x, mrd(fetch16())); return 1'b1; end
      8'h88: begin c_y = c_y - 8'd1; set_nz(c_y); return 1'b1; end
      8'hC8: begin c_y = c_y + 8'd1; set_nz(c_y); return 1'b1; end
      8'hCA: begin c_x = c_x - 8'd1; set_nz(c_x); return 1'b1; end
      8'hE8: begin c_x = c_x + 8'd1; set_nz(c_x); return 1'b1; end
      8'h8A: begin c_a = c_x; set_nz(c_a); return 1'b1; end
      8'h98: begin c_a = c_y; set_nz(c_a); return 1'b1; end
      8'h9A: begin c_sp = c_x; return 1'b1; end
      8'hA8: begin c_y = c_a; set_nz(c_y); return 1'b1; end
      8'hAA: begin c_x = c_a; set_nz(c_x); return 1'b1; end
      8'hBA: begin c_x = c_sp; set_nz(c_x); return 1'b1; end
      8'hEA: return 1'b1;
      8'h0A, 8'h2A, 8'h4A, 8'h6A: begin c_a = shift_step(sel, c_a); return 1'b1; end
      default: ;
    endcase

    if (op[1:0] == 2'd1) begin
      if (sel == 3'd4 && bbb == 3'd2) return 1'b0;
      case (bbb)
        3'd0: a = ea_zpptr(fetch8() + c_x);
        3'd1: a = ea_zp_idx(8'd0);
        3'd2: a = ea_imm();
        3'd3: a = fetch16();
        3'd4: a = ea_zpptr(fetch8()) + {8'd0, c_y};
        3'd5: a = ea_zp_idx(c_x);
        3'd6: a = fetch16() + {8'd0, c_y};
        default: a = fetch16() + {8'd0, c_x};
      endcase
      if (sel == 3'd4) begin
        mwr(a, c_a);
        return 1'b1;
      end
      m = mrd(a);
      case (sel)
        3'd0: begin c_a = c_a | m; set_nz(c_a); end
        3'd1: begin c_a = c_a & m; set_nz(c_a); end
        3'd2: begin c_a = c_a ^ m; set_nz(c_a); end
        3'd3: add8(m);
        3'd5: begin c_a = m; set_nz(c_a); end
        3'd6: cmp8(c_a, m);
        default: add8(~m);
      endcase
      return 1'b1;
    end

    if (op[1:0] == 2'd2 && bbb[0] && sel != 3'd4 && sel != 3'd5) begin
      case (bbb)
        3'd1: a = ea_zp_idx(8'd0);
        3'd3: a = fetch16();
        3'd5: a = ea_zp_idx(c_x);
        default: a = fetch16() + {8'd0, c_x};
      endcase
      m = mrd(a);
      mwr(a, shift_step(sel, m));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic cpu_view_t cpu_apply(input logic [1:0] c, input logic [15:0] addr,
                                          input logic [7:0] d);
    cpu_view_t v;
    v.rb = 8'd0;
    v.bad = 1'b0;
    case (c)
      CMD_LOAD: mwr(addr, d);
      CMD_READ: v.rb = mrd(addr);
      CMD_EXEC: begin
        if (!c_started) begin
          c_started = 1'b1;
          c_pc = {mrd(VEC_RESET + 16'd1), mrd(VEC_RESET)};
        end else begin
          v.bad = !cpu_execute();
        end
      end
      default: ;
    endcase
    v.pc = c_pc;
    v.a = c_a;
    v.x = c_x;
    v.y = c_y;
    v.sp = c_sp;
    v.p = c_p;
    return v;
  endfunction

  // Dry run of the next execute: collects unwritten addresses it would read.
  function automatic bit probe_exec();
    logic [15:0] s_pc;
    logic [7:0]  s_a, s_x, s_y, s_sp, s_p;
    bit          s_started;
    cpu_view_t   v;
    s_pc = c_pc; s_a = c_a; s_x = c_x; s_y = c_y; s_sp = c_sp; s_p = c_p;
    s_started = c_started;
    missing.delete();
    dry = 1'b1;
    v = cpu_apply(CMD_EXEC, 16'd0, 8'd0);
    dry = 1'b0;
    c_pc = s_pc; c_a = s_a; c_x = s_x; c_y = s_y; c_sp = s_sp; c_p = s_p;
    c_started = s_started;
    return v.bad;
  endfunction

  function automatic logic [7:0] pick_official_opcode();
    logic [7:0] op, s_byte;
    bit s_set, bad;
    s_byte = mem_img[c_pc];
    s_set = mem_set[c_pc];
    forever begin
      op = 8'($urandom);
      mem_img[c_pc] = op;
      mem_set[c_pc] = 1'b1;
      bad = probe_exec();
      if (!bad) break;
    end
    mem_img[c_pc] = s_byte;
    mem_set[c_pc] = s_set;
    return op;
  endfunction

  task automatic send_cmd(input logic [1:0] c, input logic [15:0] addr, input logic [7:0] d);
    int g;
    cpu_view_t v;
    g = no_idle ? 0 : pick_gap();
    repeat (g) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= c;
    cmd_ch.mem_addr <= addr;
    cmd_ch.mem_data <= d;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    v = cpu_apply(c, addr, d);
    expected_views.push_back(v);
    n_sent++;
    if (c == CMD_EXEC) n_exec++;
    if (v.bad) n_bad++;
  endtask

  // Execute one instruction, first loading every unwritten byte it would read.
  task automatic run_exec(input bit fresh_opcode);
    int unsigned need[$];
    if (fresh_opcode && c_started && !mem_set[c_pc])
      send_cmd(CMD_LOAD, c_pc, pick_official_opcode());
    forever begin
      void'(probe_exec());
      if (missing.size() == 0) break;
      need = missing;
      foreach (need[i])
        if (!mem_set[need[i]]) send_cmd(CMD_LOAD, 16'(need[i]), 8'($urandom));
    end
    send_cmd(CMD_EXEC, 16'($urandom), 8'($urandom));
  endtask

  task automatic read_written();
    send_cmd(CMD_READ, 16'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]),
             8'($urandom));
  endtask

  task automatic test_directed();
    send_cmd(CMD_LOAD, VEC_RESET, 8'h00);
    send_cmd(CMD_LOAD, VEC_RESET + 16'd1, 8'h02);
    send_cmd(CMD_LOAD, 16'h0000, 8'hFF);
    send_cmd(CMD_LOAD, 16'hFFFE, 8'h00);
    send_cmd(CMD_LOAD, 16'hFFFF, 8'h03);
    send_cmd(CMD_READ, 16'h0000, 8'hFF);
    send_cmd(CMD_READ, 16'hFFFF, 8'h00);
    send_cmd(CMD_NONE, 16'hFFFF, 8'hFF);
    run_exec(1'b0);  // vector fetch
    // LDA #FF; ADC #01; SED; BRK pad; then RTI at the vector; unknown opcode; JMP (10FF)
    send_cmd(CMD_LOAD, 16'h0200, 8'hA9);
    send_cmd(CMD_LOAD, 16'h0201, 8'hFF);
    send_cmd(CMD_LOAD, 16'h0202, 8'h69);
    send_cmd(CMD_LOAD, 16'h0203, 8'h01);
    send_cmd(CMD_LOAD, 16'h0204, 8'hF8);
    send_cmd(CMD_LOAD, 16'h0205, 8'h00);
    send_cmd(CMD_LOAD, 16'h0300, 8'h40);
    send_cmd(CMD_LOAD, 16'h0207, 8'h02);
    send_cmd(CMD_LOAD, 16'h0208, 8'h6C);
    send_cmd(CMD_LOAD, 16'h0209, 8'hFF);
    send_cmd(CMD_LOAD, 16'h020A, 8'h10);
    repeat (7) run_exec(1'b0);
  endtask

  task automatic test_stall_pressure();
    @(posedge clk);
    hold_req <= 1'b1;
    no_idle = 1;
    repeat (4) run_exec(1'b1);
    no_idle = 0;
  endtask

  task automatic test_drain_pause();
    // drop the last beat's valid so it is not taken again while idle
    cmd_ch.valid <= 1'b0;
    wait (expected_views.size() == 0);
    repeat ($urandom_range(5, 30)) @(posedge clk);
  endtask

  task automatic test_random(input int count);
    int start, r;
    start = n_sent;
    while (n_sent - start < count) begin
      no_idle = ((n_sent - start) > 400 && (n_sent - start) < 550);
      r = $urandom_range(0, 99);
      if (r < 65) run_exec($urandom_range(0, 99) < 88);
      else if (r < 80) send_cmd(CMD_LOAD, 16'($urandom), 8'($urandom));
      else if (r < 94) read_written();
      else if (r < 97) send_cmd(CMD_NONE, 16'($urandom), 8'($urandom));
      else test_drain_pause();
    end
    no_idle = 0;
  endtask

  // Result side: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      res_ch.ready <= 1'b0;
      rx_wait <= HOLD_CYCLES;
    end else if (rx_wait > 0) begin
      res_ch.ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (res_ch.valid && res_ch.ready) begin
      if (no_idle) begin
        res_ch.ready <= 1'b1;
      end else begin
        rx_wait <= pick_gap();
        res_ch.ready <= 1'b0;
      end
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cpu_view_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.prog_counter, res_ch.accum, res_ch.index_x, res_ch.index_y,
              res_ch.stack_ptr, res_ch.status_flags, res_ch.read_byte, res_ch.bad_opcode};
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_views.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected pc=%h a=%h x=%h y=%h sp=%h p=%h rb=%h bad=%b,",
                     want.pc, want.a, want.x, want.y, want.sp, want.p, want.rb, want.bad,
                     " got pc=%h a=%h x=%h y=%h sp=%h p=%h rb=%h bad=%b",
                     got.pc, got.a, got.x, got.y, got.sp, got.p, got.rb, got.bad);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    for (int i = 0; i < 65536; i++) begin
      mem_img[i] = 8'd0;
      mem_set[i] = 1'b0;
    end
    c_pc = 16'd0; c_a = 8'd0; c_x = 8'd0; c_y = 8'd0; c_sp = 8'd0;
    c_p = P_RESET;
    c_started = 1'b0;
    dry = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_LOAD;
    cmd_ch.mem_addr = 16'd0;
    cmd_ch.mem_data = 8'd0;
    res_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_stall_pressure();
    test_drain_pause();
    test_random(RANDOM_ITEMS);
    test_stall_pressure();

    @(posedge clk);
    cmd_ch.valid <= 1'b0;
    wait (expected_views.size() == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d commands, %0d of them executes (%0d unknown opcodes),", n_sent, n_exec,
             n_bad, " touching %0d memory bytes", written_addrs.size());
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching beats", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
